/* hdl/tbfd_pkg.sv */
// Shared types and constants of the trackball frame decoder.
// Holds the frame geometry, the motion codes and the front-to-back command word.
// No dependencies.
`default_nettype none

package tbfd_pkg;

  // Frame geometry: sync byte, two code bytes, then trailing bytes up to the frame end
  localparam int unsigned FRAME_BYTES = 4;
  localparam int unsigned PHASE_W     = $clog2(FRAME_BYTES);
  localparam logic [PHASE_W-1:0] PHASE_HUNT  = '0;
  localparam logic [PHASE_W-1:0] PHASE_HIGH  = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PHASE_LOW   = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(FRAME_BYTES - 1);

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // Motion codes formed from bytes 1 and 2 of a frame
  localparam logic [15:0] CODE_UP    = 16'h00FE;
  localparam logic [15:0] CODE_DOWN  = 16'h0001;
  localparam logic [15:0] CODE_LEFT  = 16'hFE00;
  localparam logic [15:0] CODE_RIGHT = 16'h0100;

  // Key bits of the result word
  localparam logic [3:0] KEY_UP    = 4'h1;
  localparam logic [3:0] KEY_DOWN  = 4'h2;
  localparam logic [3:0] KEY_LEFT  = 4'h4;
  localparam logic [3:0] KEY_RIGHT = 4'h8;

  // Per-direction count slots
  localparam int unsigned NUM_DIRS = 4;
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam int unsigned   COUNT_W   = 16;
  localparam logic [15:0]   COUNT_MAX = 16'hFFFF;
  localparam logic [15:0]   MIN_COUNT_RESET = 16'd2;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_KEYS,
    OP_UP,
    OP_DOWN,
    OP_LEFT,
    OP_RIGHT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic frame_done;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/trackball_frame_decoder.sv */
// Trackball frame decoder, top level: threshold register, front, queue, back.
// Depends on tbfd_pkg, tbfd_front, tbfd_queue and tbfd_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per received
//   byte (action_i = 0, rx_byte_i) or per silence/error event (action_i = 1).
//   Every input word yields exactly one result word on the output channel
//   (out_valid_o / out_stall_i): keys, vertical and horizontal position and
//   a frame-done flag.
//   When nothing waits, an accepted word goes into the command queue and
//   from there into the output register, where out_valid_o rises.
//   Throughput is one word per cycle while out_stall_i is low; the limit
//   is the single output register, refilled in the cycle it is taken.
//   While the receiver stalls, the result holds and the 2-entry command
//   queue fills; then in_stall_o rises and drops in the cycle after a
//   result is taken.
//   Reset clears frame phase, counts, positions and keys, empties the queue
//   and loads the threshold with 2. cfg_we_i/cfg_wdata_i write the
//   threshold; the new value applies to words processed afterwards.
`default_nettype none

module trackball_frame_decoder import tbfd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [3:0]              keys_o,
  output logic signed [31:0]      vertical_pos_o,
  output logic signed [31:0]      horizontal_pos_o,
  output logic                    frame_done_o
);

  logic [COUNT_W-1:0] min_count_q;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_valid;
  cmd_t               front_cmd;
  cmd_t               back_cmd;

  // Key threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q <= MIN_COUNT_RESET;
    end else if (cfg_we_i) begin
      min_count_q <= cfg_wdata_i;
    end
  end

  tbfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  tbfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (back_cmd)
  );

  tbfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .cmd_i            (back_cmd),
    .pop_o            (pop),
    .min_count_i      (min_count_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .keys_o           (keys_o),
    .vertical_pos_o   (vertical_pos_o),
    .horizontal_pos_o (horizontal_pos_o),
    .frame_done_o     (frame_done_o)
  );

endmodule

`default_nettype wire

/* hdl/tbfd_front.sv */
// Front part of the trackball frame decoder: accepts words, tracks frame phase
// and turns each word into a command for the back part. Uses tbfd_pkg.
`default_nettype none

module tbfd_front import tbfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       action_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [7:0]         code_high_q, code_high_d;
  logic [7:0]         code_low_q, code_low_d;
  logic [15:0]        code;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Code of the frame being closed; with a 3-byte frame the low byte arrives now
  assign code = {code_high_q, (phase_q == PHASE_LOW) ? rx_byte_i : code_low_q};

  // Phase tracking and classification
  always_comb begin
    phase_d          = phase_q;
    code_high_d      = code_high_q;
    code_low_d       = code_low_q;
    cmd_o.op         = OP_KEYS;
    cmd_o.frame_done = 1'b0;
    if (action_i) begin
      phase_d  = PHASE_HUNT;
      cmd_o.op = OP_CLEAR;
    end else if (phase_q == PHASE_HUNT) begin
      if (rx_byte_i == SYNC_BYTE) begin
        phase_d = PHASE_HIGH;
      end
    end else begin
      if (phase_q == PHASE_HIGH) begin
        code_high_d = rx_byte_i;
      end else if (phase_q == PHASE_LOW) begin
        code_low_d = rx_byte_i;
      end
      if (phase_q >= PHASE_LAST) begin
        phase_d          = PHASE_HUNT;
        cmd_o.frame_done = 1'b1;
        unique case (code)
          CODE_UP:    cmd_o.op = OP_UP;
          CODE_DOWN:  cmd_o.op = OP_DOWN;
          CODE_LEFT:  cmd_o.op = OP_LEFT;
          CODE_RIGHT: cmd_o.op = OP_RIGHT;
          default:    cmd_o.op = OP_KEYS;
        endcase
      end else begin
        phase_d = phase_q + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PHASE_HUNT;
      code_high_q <= '0;
      code_low_q  <= '0;
    end else if (push_o) begin
      phase_q     <= phase_d;
      code_high_q <= code_high_d;
      code_low_q  <= code_low_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/tbfd_queue.sv */
// Short command queue between the front and back parts of the decoder.
// Depth from tbfd_pkg::QUEUE_DEPTH.
`default_nettype none

module tbfd_queue import tbfd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/tbfd_back.sv */
// Back part of the decoder: direction counts, positions, key bits and the
// output register. Consumes commands from tbfd_queue. Uses tbfd_pkg.
`default_nettype none

module tbfd_back import tbfd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    pop_o,
  input  wire logic [COUNT_W-1:0] min_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [3:0]              keys_o,
  output logic signed [31:0]      vertical_pos_o,
  output logic signed [31:0]      horizontal_pos_o,
  output logic                    frame_done_o
);

  logic [COUNT_W-1:0] count_q [NUM_DIRS];
  logic [COUNT_W-1:0] count_d [NUM_DIRS];
  logic signed [31:0] vacc_q, vacc_d;
  logic signed [31:0] hacc_q, hacc_d;
  logic [3:0]         keys_q, keys_d;
  logic               done_q;
  logic               out_valid_q;
  logic               out_free;

  // Output register is free when empty or being taken this cycle
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = q_valid_i & out_free;

  // Count, position and key update for one command
  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      count_d[i] = count_q[i];
    end
    vacc_d = vacc_q;
    hacc_d = hacc_q;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        for (int i = 0; i < NUM_DIRS; i++) begin
          count_d[i] = '0;
        end
      end
      OP_KEYS: ;
      OP_UP: begin
        if (count_q[DIR_UP] != COUNT_MAX) count_d[DIR_UP] = count_q[DIR_UP] + 16'd1;
        vacc_d = vacc_q + 32'sd1;
      end
      OP_DOWN: begin
        if (count_q[DIR_DOWN] != COUNT_MAX) count_d[DIR_DOWN] = count_q[DIR_DOWN] + 16'd1;
        vacc_d = vacc_q - 32'sd1;
      end
      OP_LEFT: begin
        if (count_q[DIR_LEFT] != COUNT_MAX) count_d[DIR_LEFT] = count_q[DIR_LEFT] + 16'd1;
        hacc_d = hacc_q - 32'sd1;
      end
      OP_RIGHT: begin
        if (count_q[DIR_RIGHT] != COUNT_MAX) count_d[DIR_RIGHT] = count_q[DIR_RIGHT] + 16'd1;
        hacc_d = hacc_q + 32'sd1;
      end
      default: ;
    endcase

    // Keys from the new counts: up wins over down, left over right
    keys_d = '0;
    if (cmd_i.op != OP_CLEAR) begin
      if (count_d[DIR_UP] >= min_count_i) begin
        keys_d = keys_d | KEY_UP;
      end else if (count_d[DIR_DOWN] >= min_count_i) begin
        keys_d = keys_d | KEY_DOWN;
      end
      if (count_d[DIR_LEFT] >= min_count_i) begin
        keys_d = keys_d | KEY_LEFT;
      end else if (count_d[DIR_RIGHT] >= min_count_i) begin
        keys_d = keys_d | KEY_RIGHT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIRS; i++) begin
        count_q[i] <= '0;
      end
      vacc_q      <= '0;
      hacc_q      <= '0;
      keys_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        for (int i = 0; i < NUM_DIRS; i++) begin
          count_q[i] <= count_d[i];
        end
        vacc_q <= vacc_d;
        hacc_q <= hacc_d;
        keys_q <= keys_d;
      end
      if (out_free) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  // Done flag rides with the result word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      done_q <= cmd_i.frame_done;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign keys_o           = keys_q;
  assign vertical_pos_o   = vacc_q;
  assign horizontal_pos_o = hacc_q;
  assign frame_done_o     = done_q;

endmodule

`default_nettype wire

/* hdl/tbfd_checker.sv */
// Port-level checks of the trackball frame decoder, bound to the top level.
// Depends on trackball_frame_decoder ports only.
`default_nettype none

module tbfd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [3:0]         keys_o,
  input wire logic signed [31:0] vertical_pos_o,
  input wire logic signed [31:0] horizontal_pos_o,
  input wire logic               frame_done_o
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Positions only move with a completed frame
  a_move_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vertical_pos_o != $past(vertical_pos_o)) ||
    (horizontal_pos_o != $past(horizontal_pos_o)) |-> out_valid_o && frame_done_o)
    else $error("position moved without a completed frame");

  // One frame moves one axis at most
  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((vertical_pos_o != $past(vertical_pos_o)) &&
      (horizontal_pos_o != $past(horizontal_pos_o))))
    else $error("both axes moved in one step");

  // Opposite keys are never asserted together
  a_key_priority: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(keys_o[0] && keys_o[1]) && !(keys_o[2] && keys_o[3]))
    else $error("opposite direction keys both set");

endmodule

bind trackball_frame_decoder tbfd_checker u_tbfd_checker (.*);

`default_nettype wire

/* dv/tbfd_motion_checker.sv */
// Checker for the trackball frame decoder: predicts every result word and compares it.
// Holds the testbench package (action codes, result word) and the checker module.
// Depends on tbfd_pkg.

package tbfd_tb_pkg;

  // Meaning of the action field of an input word
  localparam logic ACT_BYTE       = 1'b0;
  localparam logic ACT_LINE_EVENT = 1'b1;

  typedef struct packed {
    logic [3:0]         keys;
    logic signed [31:0] vertical_pos;
    logic signed [31:0] horizontal_pos;
    logic               frame_done;
  } motion_word_t;

endpackage

module tbfd_motion_checker import tbfd_pkg::*, tbfd_tb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [3:0]         keys_i,
  input  logic signed [31:0] vertical_pos_i,
  input  logic signed [31:0] horizontal_pos_i,
  input  logic               frame_done_i,
  output int                 err_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the decoder state
  logic [COUNT_W-1:0] threshold;
  logic [PHASE_W-1:0] phase;
  logic [7:0]         code_high;
  logic [7:0]         code_low;
  logic [COUNT_W-1:0] dir_count [NUM_DIRS];
  logic signed [31:0] vert_acc;
  logic signed [31:0] horiz_acc;
  logic [3:0]         key_state;

  motion_word_t expected_motion_q [$];
  int           mismatches = 0;

  assign err_count_o = mismatches;

  function void clear_counts();
    for (int d = 0; d < NUM_DIRS; d++) dir_count[d] = '0;
  endfunction

  // saturating per-direction count
  function void bump_count(input logic [1:0] dir);
    if (dir_count[dir] != COUNT_MAX) dir_count[dir] = dir_count[dir] + COUNT_W'(1);
  endfunction

  // Motion frame: count it and move the position, which wraps
  function void apply_motion(input logic [15:0] code);
    case (code)
      CODE_UP: begin
        bump_count(DIR_UP);
        vert_acc = vert_acc + 32'sd1;
      end
      CODE_DOWN: begin
        bump_count(DIR_DOWN);
        vert_acc = vert_acc - 32'sd1;
      end
      CODE_LEFT: begin
        bump_count(DIR_LEFT);
        horiz_acc = horiz_acc - 32'sd1;
      end
      CODE_RIGHT: begin
        bump_count(DIR_RIGHT);
        horiz_acc = horiz_acc + 32'sd1;
      end
      default: ;
    endcase
  endfunction

  // One input word in, the expected result word out
  function motion_word_t decode_word(input logic act, input logic [7:0] rx);
    motion_word_t w;
    logic         done;
    done = 1'b0;
    if (act == ACT_LINE_EVENT) begin
      // silence/error drops the frame, counts and keys; positions stay
      phase = PHASE_HUNT;
      clear_counts();
      key_state = '0;
    end else begin
      if (phase == PHASE_HUNT) begin
        if (rx == SYNC_BYTE) phase = PHASE_HIGH;
      end else begin
        if (phase == PHASE_HIGH) code_high = rx;
        else if (phase == PHASE_LOW) code_low = rx;
        if (phase >= PHASE_LAST) begin
          apply_motion({code_high, code_low});
          done  = 1'b1;
          phase = PHASE_HUNT;
        end else begin
          phase = phase + PHASE_W'(1);
        end
      end
      // keys rebuilt on every byte; up beats down, left beats right
      key_state = '0;
      if (dir_count[DIR_UP] >= threshold) key_state |= KEY_UP;
      else if (dir_count[DIR_DOWN] >= threshold) key_state |= KEY_DOWN;
      if (dir_count[DIR_LEFT] >= threshold) key_state |= KEY_LEFT;
      else if (dir_count[DIR_RIGHT] >= threshold) key_state |= KEY_RIGHT;
    end
    w.keys           = key_state;
    w.vertical_pos   = vert_acc;
    w.horizontal_pos = horiz_acc;
    w.frame_done     = done;
    return w;
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Watch both channels; results are taken before new words are queued
  always @(posedge clk_i or negedge rst_ni) begin
    motion_word_t want;
    if (!rst_ni) begin
      threshold = MIN_COUNT_RESET;
      phase     = PHASE_HUNT;
      code_high = '0;
      code_low  = '0;
      clear_counts();
      vert_acc  = '0;
      horiz_acc = '0;
      key_state = '0;
      expected_motion_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) threshold = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_motion_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, got keys %h vert %h horiz %h done %b",
                   $time, keys_i, vertical_pos_i, horizontal_pos_i, frame_done_i);
        end else begin
          want = expected_motion_q.pop_front();
          check_field("keys", 32'(want.keys), 32'(keys_i));
          check_field("vertical_pos", want.vertical_pos, vertical_pos_i);
          check_field("horizontal_pos", want.horizontal_pos, horizontal_pos_i);
          check_field("frame_done", 32'(want.frame_done), 32'(frame_done_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_motion_q.push_back(decode_word(action_i, rx_byte_i));
      pending_o <= expected_motion_q.size();
    end
  end

endmodule

/* dv/tb_trackball_frame_decoder.sv */
// Testbench top for the trackball frame decoder: clock, reset, byte stimulus and verdict.
// Depends on tbfd_pkg, tbfd_tb_pkg, tbfd_motion_checker and trackball_frame_decoder.

module tb_trackball_frame_decoder import tbfd_pkg::*, tbfd_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 280;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               action_i    = ACT_BYTE;
  logic [7:0]         rx_byte_i   = '0;
  logic               cfg_we_i    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [3:0]         keys_o;
  logic signed [31:0] vertical_pos_o;
  logic signed [31:0] horizontal_pos_o;
  logic               frame_done_o;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int words_sent  = 0;
  int cycles      = 0;
  int mismatches;
  int pending;

  // Idling per phase: none, sender, receiver, both
  int                 idle_by_phase [4]      = '{0, 70, 0, 34};
  int                 stall_by_phase [4]     = '{0, 0, 70, 34};
  logic [COUNT_W-1:0] threshold_by_phase [4] = '{16'd1, 16'd0, 16'd3, 16'd2};

  trackball_frame_decoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .rx_byte_i        (rx_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .keys_o           (keys_o),
    .vertical_pos_o   (vertical_pos_o),
    .horizontal_pos_o (horizontal_pos_o),
    .frame_done_o     (frame_done_o)
  );

  tbfd_motion_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .rx_byte_i        (rx_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .keys_i           (keys_o),
    .vertical_pos_i   (vertical_pos_o),
    .horizontal_pos_i (horizontal_pos_o),
    .frame_done_i     (frame_done_o),
    .err_count_o      (mismatches),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_trackball_frame_decoder: errors");
      $finish;
    end
  end

  // One word, after a random gap; returns at the accepting edge
  task send_word(input logic act, input logic [7:0] rx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Sync, the two code bytes, then the trailing bytes
  task send_frame(input logic [15:0] code, input logic [7:0] trailer);
    send_word(ACT_BYTE, SYNC_BYTE);
    send_word(ACT_BYTE, code[15:8]);
    send_word(ACT_BYTE, code[7:0]);
    for (int i = 3; i < FRAME_BYTES; i++) send_word(ACT_BYTE, trailer);
  endtask

  // Stop offering and wait for every result to come back
  task settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task write_threshold(input logic [COUNT_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly motion frames; the rest unknown codes, noise, cut frames, line events
  task random_traffic(input int n);
    int          start;
    int          pick;
    logic [15:0] code;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        case ($urandom_range(0, 3))
          0:       code = CODE_UP;
          1:       code = CODE_DOWN;
          2:       code = CODE_LEFT;
          default: code = CODE_RIGHT;
        endcase
        send_frame(code, 8'($urandom_range(0, 255)));
      end else if (pick < 74) begin
        send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end else if (pick < 84) begin
        send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        // frame cut short by a line event
        send_word(ACT_BYTE, SYNC_BYTE);
        repeat ($urandom_range(0, FRAME_BYTES - 2))
          send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_word(ACT_LINE_EVENT, 8'($urandom_range(0, 255)));
      end else begin
        send_word(ACT_LINE_EVENT, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset threshold, no idling
    send_word(ACT_BYTE, 8'h00);          // dropped while hunting
    send_word(ACT_BYTE, 8'hFE);
    send_frame(CODE_UP, 8'h00);
    send_frame(CODE_UP, SYNC_BYTE);      // sync value as trailer is no new frame
    send_frame(CODE_DOWN, 8'h7F);
    send_frame(16'hFFFF, 8'h80);         // unknown code made of sync values
    send_word(ACT_LINE_EVENT, 8'hFF);    // keys and counts cleared, positions kept
    send_frame(CODE_LEFT, 8'h01);        // horizontal goes negative
    send_frame(CODE_RIGHT, 8'hFF);
    settle();

    // Random phases, one threshold and one idling pattern each
    for (int p = 0; p < 4; p++) begin
      idle_pct   = idle_by_phase[p];
      stall_pct <= stall_by_phase[p];
      write_threshold(threshold_by_phase[p]);
      if (p == 0) hold_asked <= hold_asked + 1;
      random_traffic(PHASE_WORDS);
      settle();
    end

    // Highest threshold: a short run of motion never sets a key
    idle_pct   = 0;
    stall_pct <= 0;
    write_threshold(COUNT_MAX);
    send_word(ACT_LINE_EVENT, 8'h00);
    repeat (6) send_frame(CODE_UP, 8'($urandom_range(0, 255)));
    repeat (2) send_frame(CODE_DOWN, 8'($urandom_range(0, 255)));
    settle();

    // Short mixed tail at a random small threshold
    idle_pct   = 34;
    stall_pct <= 34;
    write_threshold(COUNT_W'($urandom_range(1, 8)));
    random_traffic(100);
    settle();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("tb_trackball_frame_decoder: clean");
    end else begin
      $display("tb_trackball_frame_decoder: errors");
    end
    $finish;
  end

endmodule
